>>> rtl/core/mma_pkg.sv
// Shared types and constants for the matrix multiply-accumulate unit.
// Used by the top level and mma_mac under rtl/core; depends on nothing else.
package mma_pkg;

   // default sizes of the stores and of the arithmetic
   localparam int DIM_MAX_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 32;
   localparam int ACC_WIDTH_DEF  = 64;

   // port widths fixed by the stream formats
   localparam int REQ_DATA_W = 104;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 72;
   localparam int RSP_USER_W = 1;
   localparam int SIZE_W     = 4;

   // matrix_size after reset
   localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

   // command carried in req_tuser
   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_LOAD_C = 2'd2,
      CMD_START  = 2'd3
   } mma_cmd_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_C_READ,
      ST_C_LOAD,
      ST_MUL,
      ST_ADD,
      ST_WB,
      ST_OUT
   } mma_state_type;

   // controls from the sequencer to the MAC datapath
   typedef struct packed {
      logic load;   // take the starting C value, clear the clip flag
      logic mul;    // register the product of the operands
      logic add;    // saturating add of the product into the accumulator
   } mma_mac_ctl_type;

endpackage

>>> rtl/core/matrix_multiply_accumulate_unit.sv
// Top level of the matrix multiply-accumulate unit: sequencer, stores and stream ports.
// Depends on mma_pkg, mma_ram and mma_mac.
//
//  channel | direction | tdata (low bit up)                            | tuser     | tlast
//  req_    | in        | row, col, operand_value, accum_init, pad      | command   | -
//  rsp_    | out       | out_row, out_col, result_value, pad           | saturated | last
//  csr_    | in        | matrix_size on csr_wr_data when csr_wr_en     | -         | -
//
// A load needs only the idle state; req_tready drops only while a start is running.
// A start with size n steps through each entry in turn: a C read, a load, a multiply
// and an add per product on the shared multiplier and adder, a write-back and an output
// state. rsp_tready low holds the entry and stops the sequencer.
// Reset clears all C valid bits at once, so there is no clearing pass.
module matrix_multiply_accumulate_unit #(
   parameter int DIM_MAX    = mma_pkg::DIM_MAX_DEF,
   parameter int ELEM_WIDTH = mma_pkg::ELEM_WIDTH_DEF,
   parameter int ACC_WIDTH  = mma_pkg::ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request stream
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // row[2:0], col[5:3], operand_value[37:6], accum_init[101:38], zero[103:102]
   input  logic [mma_pkg::REQ_DATA_W-1:0] req_tdata,
   // command[1:0]
   input  logic [mma_pkg::REQ_USER_W-1:0] req_tuser,
   // response stream
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // out_row[2:0], out_col[5:3], result_value[69:6], zero[71:70]
   output logic [mma_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // saturated[0]
   output logic [mma_pkg::RSP_USER_W-1:0] rsp_tuser,
   output logic                           rsp_tlast,
   // configuration
   input  logic                           csr_wr_en,
   input  logic [mma_pkg::SIZE_W-1:0]     csr_wr_data
);
   import mma_pkg::*;

   localparam int DEPTH  = DIM_MAX * DIM_MAX;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int IDX_W  = (DIM_MAX > 1) ? $clog2(DIM_MAX) : 1;
   localparam logic [ADDR_W-1:0] DIM_A = ADDR_W'(DIM_MAX);
   localparam logic signed [63:0] ACC_MAX64 = (64'sd1 <<< (ACC_WIDTH - 1)) - 64'sd1;
   localparam logic signed [63:0] ACC_MIN64 = -ACC_MAX64 - 64'sd1;

   mma_state_type     state_ff, state_in;
   logic [SIZE_W-1:0] size_ff;
   logic [IDX_W-1:0]  nm1_ff, nm1_in;
   logic [IDX_W-1:0]  i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [DEPTH-1:0]  cvalid_ff;

   // request fields
   mma_cmd_type        cmd;
   logic [2:0]         req_row, req_col;
   logic [31:0]        req_operand;
   logic signed [63:0] req_accum;
   logic               req_xfer, rsp_xfer, in_range, entry_last, k_last;

   // store ports
   logic [ADDR_W-1:0]            load_addr, c_addr, a_rd_addr, b_rd_addr, c_wr_addr;
   logic [IDX_W-1:0]             k_sel;
   logic                         a_wr_en, b_wr_en, c_wr_en;
   logic [ELEM_WIDTH-1:0]        a_rd_data, b_rd_data;
   logic [ACC_WIDTH-1:0]         c_rd_data, c_wr_data, c_load_data;
   logic signed [63:0]           accum_clamped;

   // MAC
   mma_mac_ctl_type             mac_ctl;
   logic signed [ACC_WIDTH-1:0] mac_init, mac_acc;
   logic                        mac_clip;

   assign cmd         = mma_cmd_type'(req_tuser);
   assign req_row     = req_tdata[2:0];
   assign req_col     = req_tdata[5:3];
   assign req_operand = req_tdata[37:6];
   assign req_accum   = req_tdata[101:38];
   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_xfer    = rsp_tvalid && rsp_tready;
   assign in_range    = ({1'b0, req_row} < SIZE_W'(DIM_MAX))
                        && ({1'b0, req_col} < SIZE_W'(DIM_MAX));
   assign entry_last  = (i_ff == nm1_ff) && (j_ff == nm1_ff);
   assign k_last      = (k_ff == nm1_ff);

   // store addresses
   assign load_addr = ADDR_W'(req_row) * DIM_A + ADDR_W'(req_col);
   assign c_addr    = ADDR_W'(i_ff) * DIM_A + ADDR_W'(j_ff);
   assign k_sel     = ((state_ff == ST_ADD) && !k_last) ? k_ff + IDX_W'(1) : k_ff;
   assign a_rd_addr = ADDR_W'(i_ff) * DIM_A + ADDR_W'(k_sel);
   assign b_rd_addr = ADDR_W'(k_sel) * DIM_A + ADDR_W'(j_ff);

   // clamp a C load to the accumulator range
   always_comb begin
      if (req_accum > ACC_MAX64) begin
         accum_clamped = ACC_MAX64;
      end else if (req_accum < ACC_MIN64) begin
         accum_clamped = ACC_MIN64;
      end else begin
         accum_clamped = req_accum;
      end
   end
   assign c_load_data = ACC_WIDTH'(accum_clamped);

   // size register
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= SIZE_RESET;
      end else if (csr_wr_en) begin
         size_ff <= csr_wr_data;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (cmd == CMD_START)) begin
               state_in = ST_C_READ;
            end
         end
         ST_C_READ: state_in = ST_C_LOAD;
         ST_C_LOAD: state_in = ST_MUL;
         ST_MUL:    state_in = ST_ADD;
         ST_ADD:    state_in = k_last ? ST_WB : ST_MUL;
         ST_WB:     state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_xfer) begin
               state_in = entry_last ? ST_IDLE : ST_C_READ;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs and counter updates
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      a_wr_en    = 1'b0;
      b_wr_en    = 1'b0;
      c_wr_en    = 1'b0;
      c_wr_addr  = load_addr;
      c_wr_data  = c_load_data;
      mac_ctl    = '0;
      nm1_in     = nm1_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_xfer) begin
               case (cmd)
                  CMD_LOAD_A: a_wr_en = in_range;
                  CMD_LOAD_B: b_wr_en = in_range;
                  CMD_LOAD_C: c_wr_en = in_range;
                  CMD_START: begin
                     i_in = '0;
                     j_in = '0;
                     k_in = '0;
                     if (size_ff == '0) begin
                        nm1_in = '0;
                     end else if (size_ff > SIZE_W'(DIM_MAX)) begin
                        nm1_in = IDX_W'(DIM_MAX - 1);
                     end else begin
                        nm1_in = IDX_W'(size_ff - SIZE_W'(1));
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_C_READ: ;
         ST_C_LOAD: mac_ctl.load = 1'b1;
         ST_MUL:    mac_ctl.mul  = 1'b1;
         ST_ADD: begin
            mac_ctl.add = 1'b1;
            k_in        = k_last ? '0 : k_ff + IDX_W'(1);
         end
         ST_WB: begin
            c_wr_en   = 1'b1;
            c_wr_addr = c_addr;
            c_wr_data = mac_acc;
         end
         ST_OUT: begin
            rsp_tvalid = 1'b1;
            if (rsp_xfer && !entry_last) begin
               if (j_ff == nm1_ff) begin
                  j_in = '0;
                  i_in = i_ff + IDX_W'(1);
               end else begin
                  j_in = j_ff + IDX_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         nm1_ff   <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         nm1_ff   <= nm1_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   // C valid bits: an entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff <= '0;
      end else if (c_wr_en) begin
         cvalid_ff[c_wr_addr] <= 1'b1;
      end
   end

   assign mac_init = cvalid_ff[c_addr] ? c_rd_data : '0;

   // stores
   mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_a_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (load_addr),
      .wr_data (req_operand[ELEM_WIDTH-1:0]),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mma_ram #(.WIDTH(ELEM_WIDTH), .DEPTH(DEPTH)) u_b_ram (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (load_addr),
      .wr_data (req_operand[ELEM_WIDTH-1:0]),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   mma_ram #(.WIDTH(ACC_WIDTH), .DEPTH(DEPTH)) u_c_ram (
      .clock   (clock),
      .wr_en   (c_wr_en),
      .wr_addr (c_wr_addr),
      .wr_data (c_wr_data),
      .rd_addr (c_addr),
      .rd_data (c_rd_data)
   );

   // shared multiply-accumulate
   mma_mac #(.ELEM_WIDTH(ELEM_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_mac (
      .clock      (clock),
      .ctl        (mac_ctl),
      .init_value (mac_init),
      .a_value    (a_rd_data),
      .b_value    (b_rd_data),
      .acc        (mac_acc),
      .clip       (mac_clip)
   );

   // response fields
   assign rsp_tdata = {2'b00, 64'(mac_acc), 3'(j_ff), 3'(i_ff)};
   assign rsp_tuser = mac_clip;
   assign rsp_tlast = entry_last;

   // no request taken while a result is on offer
   a_busy_excl: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request accepted while a result is pending");

   // the final transfer of a run returns the block to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && rsp_tlast) |=> req_tready)
      else $error("sequencer did not return to idle after the last entry");

   // an add always follows a product
   a_add_after_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) |-> ($past(state_ff) == ST_MUL))
      else $error("accumulate without a fresh product");

   // indices stay within the active size during a run
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> ((i_ff <= nm1_ff) && (j_ff <= nm1_ff) && (k_ff <= nm1_ff)))
      else $error("matrix index beyond the active size");

endmodule

>>> rtl/core/mma_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// Stand-alone; no package needed.
module mma_ram #(
   parameter int  WIDTH  = 32,
   parameter int  DEPTH  = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/mma_mac.sv
// Shared multiply and saturating-accumulate datapath.
// Depends on mma_pkg for the control struct.
module mma_mac #(
   parameter int ELEM_WIDTH = mma_pkg::ELEM_WIDTH_DEF,
   parameter int ACC_WIDTH  = mma_pkg::ACC_WIDTH_DEF
) (
   input  logic                         clock,
   input  mma_pkg::mma_mac_ctl_type     ctl,
   input  logic signed [ACC_WIDTH-1:0]  init_value,
   input  logic signed [ELEM_WIDTH-1:0] a_value,
   input  logic signed [ELEM_WIDTH-1:0] b_value,
   output logic signed [ACC_WIDTH-1:0]  acc,
   output logic                         clip
);
   import mma_pkg::*;

   localparam int PROD_W = 2 * ELEM_WIDTH;
   localparam int SUM_W  = ((ACC_WIDTH > PROD_W) ? ACC_WIDTH : PROD_W) + 1;
   localparam logic signed [SUM_W-1:0] SAT_HI = (SUM_W'(1) <<< (ACC_WIDTH - 1)) - SUM_W'(1);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

   logic signed [PROD_W-1:0]    prod_ff;
   logic signed [ACC_WIDTH-1:0] acc_ff, acc_in;
   logic                        clip_ff, clip_in;
   logic signed [SUM_W-1:0]     sum;

   // product register
   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         prod_ff <= a_value * b_value;
      end
   end

   // exact sum, then clamp to the accumulator range
   assign sum = SUM_W'(acc_ff) + SUM_W'(prod_ff);

   always_comb begin
      acc_in  = acc_ff;
      clip_in = clip_ff;
      if (ctl.load) begin
         acc_in  = init_value;
         clip_in = 1'b0;
      end else if (ctl.add) begin
         if (sum > SAT_HI) begin
            acc_in  = ACC_WIDTH'(SAT_HI);
            clip_in = 1'b1;
         end else if (sum < SAT_LO) begin
            acc_in  = ACC_WIDTH'(SAT_LO);
            clip_in = 1'b1;
         end else begin
            acc_in = ACC_WIDTH'(sum);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      clip_ff <= clip_in;
   end

   assign acc  = acc_ff;
   assign clip = clip_ff;

endmodule
